// ===== design/bmf2d_pkg.sv =====
// Shared types, constants and helpers for the 2-D box mean filter.
// Used by bmf2d_ctrl, bmf2d_dpath and box_mean_filter_2d_unit; no dependencies.
package bmf2d_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 7;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int RADIUS_REG_W = 3;
    localparam int ROW_W      = 14;
    localparam int RAD_W      = 4;
    localparam int MEAN_W     = 24;
    localparam int FRAC_BITS  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

    localparam logic [10:0] WIDTH_RST  = 11'd1024;
    localparam logic [12:0] HEIGHT_RST = 13'd1024;
    localparam logic [2:0]  RADIUS_RST = 3'd3;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic calc;
        logic div_step;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_out;
        logic div_done;
        logic out_free;
    } t_status;

    // number of window taps inside [0, size-1] around center
    function automatic logic [15:0] clipped_count(input logic [15:0] center,
                                                 input logic [15:0] rad,
                                                 input logic [15:0] size);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = (center >= rad) ? center - rad : 16'd0;
        hi = center + rad;
        if (hi > size - 16'd1) hi = size - 16'd1;
        return hi - lo + 16'd1;
    endfunction

endpackage

// ===== design/bmf2d_ctrl.sv =====
// Sequencer for the box mean filter: accept, column/line update, divide, output.
// Depends on bmf2d_pkg; drives bmf2d_dpath through t_cmd.
module bmf2d_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bmf2d_pkg::t_status  i_status,
    output bmf2d_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_ready          = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_status.need_out ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_calc_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_CALC)
        else $error("no update cycle after accept");
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_status.out_free) |=> r_state == S_DONE)
        else $error("result dropped while output busy");
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide phase");

endmodule

// ===== design/bmf2d_dpath.sv =====
// Datapath of the box mean filter: positions, row sum ring, line and column
// stores, serial divider, output register. Depends on bmf2d_pkg.
module bmf2d_dpath #(
    parameter int MAX_WIDTH  = bmf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = bmf2d_pkg::MAX_RADIUS_DEF,
    parameter int PIXEL_BITS = bmf2d_pkg::PIXEL_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [bmf2d_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bmf2d_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [PIXEL_BITS-1:0]                 i_pixel,
    input  bmf2d_pkg::t_cmd                       i_cmd,
    output bmf2d_pkg::t_status                    o_status,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [bmf2d_pkg::MEAN_W-1:0]          o_mean,
    output logic                                  o_last_in_frame
);

    localparam int LINES = 2 * MAX_RADIUS + 1;
    localparam int LW    = $clog2(LINES);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
    localparam int RW    = bmf2d_pkg::ROW_W;
    localparam int RADW  = bmf2d_pkg::RAD_W;
    localparam int NW    = $clog2(LINES + 1);
    localparam int HSW   = PIXEL_BITS + NW;
    localparam int CSW   = PIXEL_BITS + 2 * NW;
    localparam int CNTW  = 2 * NW;
    localparam int DVW   = CSW + bmf2d_pkg::FRAC_BITS;
    localparam int STW   = $clog2(DVW + 1);

    // configuration
    logic [bmf2d_pkg::WIDTH_REG_W-1:0]  r_cfg_w;
    logic [bmf2d_pkg::HEIGHT_REG_W-1:0] r_cfg_h;
    logic [bmf2d_pkg::RADIUS_REG_W-1:0] r_cfg_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= bmf2d_pkg::WIDTH_RST;
            r_cfg_h <= bmf2d_pkg::HEIGHT_RST;
            r_cfg_r <= bmf2d_pkg::RADIUS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bmf2d_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data[bmf2d_pkg::WIDTH_REG_W-1:0];
                bmf2d_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data[bmf2d_pkg::HEIGHT_REG_W-1:0];
                bmf2d_pkg::CFG_RADIUS: r_cfg_r <= i_cfg_data[bmf2d_pkg::RADIUS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0]   w_eff, ext_w;
    logic [RW-1:0]   h_eff, ext_h;
    logic [RADW-1:0] rad;
    logic [RADW:0]   win;

    always_comb begin
        if (r_cfg_w == '0)                 w_eff = CW'(1);
        else if (32'(r_cfg_w) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
        else                               w_eff = CW'(r_cfg_w);
        h_eff = (r_cfg_h == '0) ? RW'(1) : RW'(r_cfg_h);
        rad   = (32'(r_cfg_r) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(r_cfg_r);
        win   = {rad, 1'b1};
        ext_w = w_eff + CW'(rad);
        ext_h = h_eff + RW'(rad);
    end

    // positions; pointers track column and row modulo LINES
    logic [CW-1:0] r_col;
    logic [LW-1:0] r_cptr;
    logic [RW-1:0] r_row;
    logic [LW-1:0] r_lptr;
    logic [CW-1:0] c;
    logic [LW-1:0] cp;
    logic [RW-1:0] r;
    logic [LW-1:0] lp;

    always_comb begin
        c  = (r_col >= ext_w) ? '0 : r_col;
        cp = (r_col >= ext_w) ? '0 : r_cptr;
        r  = (r_row >= ext_h) ? '0 : r_row;
        lp = (r_row >= ext_h) ? '0 : r_lptr;
    end

    function automatic logic [LW-1:0] back_ptr(input logic [LW-1:0] p,
                                               input logic [RADW:0] d);
        logic [LW+RADW:0] t;
        t = (LW+RADW+1)'(p) + (LW+RADW+1)'(LINES) - (LW+RADW+1)'(d);
        if (t >= (LW+RADW+1)'(LINES)) t = t - (LW+RADW+1)'(LINES);
        return t[LW-1:0];
    endfunction

    // horizontal running sum
    logic [PIXEL_BITS-1:0] ring [LINES];
    logic [HSW-1:0]        r_hsum;
    logic [PIXEL_BITS-1:0] v;
    logic [HSW-1:0]        hs_n;
    logic [LW-1:0]         ring_rd;
    logic                  row_end;

    always_comb begin
        v       = (c >= w_eff || r >= h_eff) ? '0 : i_pixel;
        ring_rd = back_ptr(cp, win);
        hs_n    = ((c == '0) ? '0 : r_hsum) + HSW'(v);
        if (c >= CW'(win)) hs_n = hs_n - HSW'(ring[ring_rd]);
        row_end = (c + CW'(1) >= ext_w);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            ring[cp] <= v;
            r_hsum   <= hs_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_cptr <= '0;
            r_row  <= '0;
            r_lptr <= '0;
        end else if (i_cmd.accept) begin
            if (row_end) begin
                r_col  <= '0;
                r_cptr <= '0;
                if (r + RW'(1) >= ext_h) begin
                    r_row  <= '0;
                    r_lptr <= '0;
                end else begin
                    r_row  <= r + RW'(1);
                    r_lptr <= (lp == LW'(LINES - 1)) ? '0 : lp + LW'(1);
                end
            end else begin
                r_col  <= c + CW'(1);
                r_cptr <= (cp == LW'(LINES - 1)) ? '0 : cp + LW'(1);
            end
        end
    end

    // item captured for the vertical stage
    logic [CW-1:0]  x;
    logic [RW-1:0]  y;
    logic [CW-1:0]  r_x;
    logic [LW-1:0]  r_line;
    logic [HSW-1:0] r_hs;
    logic           r_has_col, r_has_out, r_first_row, r_sub, r_last;
    logic [NW-1:0]  r_cx, r_cy;

    assign x = c - CW'(rad);
    assign y = r - RW'(rad);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x         <= x;
            r_line      <= lp;
            r_hs        <= hs_n;
            r_has_col   <= (c >= CW'(rad));
            r_has_out   <= (c >= CW'(rad)) && (r >= RW'(rad));
            r_first_row <= (r == '0);
            r_sub       <= (r >= RW'(win));
            r_last      <= (y == h_eff - RW'(1)) && (x == w_eff - CW'(1));
            r_cx        <= NW'(bmf2d_pkg::clipped_count(16'(x), 16'(rad), 16'(w_eff)));
            r_cy        <= NW'(bmf2d_pkg::clipped_count(16'(y), 16'(rad), 16'(h_eff)));
        end
    end

    // line store of row sums and column sum store
    logic [HSW-1:0] line_mem [2**(LW+XW)];
    logic [CSW-1:0] col_mem  [2**XW];
    logic [HSW-1:0] r_line_rd;
    logic [CSW-1:0] r_col_rd;
    logic [CSW-1:0] cs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_line_rd <= line_mem[{back_ptr(lp, win), x[XW-1:0]}];
            r_col_rd  <= col_mem[x[XW-1:0]];
        end
        if (i_cmd.calc && r_has_col) begin
            line_mem[{r_line, r_x[XW-1:0]}] <= r_hs;
            col_mem[r_x[XW-1:0]]            <= cs;
        end
    end

    always_comb begin
        if (r_first_row) cs = CSW'(r_hs);
        else begin
            cs = r_col_rd + CSW'(r_hs);
            if (r_sub) cs = cs - CSW'(r_line_rd);
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [DVW-1:0]  r_dvd;
    logic [CNTW-1:0] r_den;
    logic [CNTW-1:0] r_rem;
    logic [STW-1:0]  r_step;
    logic            r_busy;
    logic [CNTW:0]   trial;
    logic            qbit;

    always_comb begin
        trial = {r_rem, r_dvd[DVW-1]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.calc) begin
            r_busy <= r_has_out;
        end else if (o_status.div_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_dvd  <= {cs, {bmf2d_pkg::FRAC_BITS{1'b0}}};
            r_den  <= CNTW'(r_cx) * CNTW'(r_cy);
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step && r_busy) begin
            r_rem  <= qbit ? CNTW'(trial - {1'b0, r_den}) : trial[CNTW-1:0];
            r_dvd  <= {r_dvd[DVW-2:0], qbit};
            r_step <= r_step + STW'(1);
        end
    end

    // output register
    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)            r_ovalid <= 1'b0;
        else if (i_cmd.load_out) r_ovalid <= 1'b1;
        else if (i_ready)        r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_mean          <= r_dvd[bmf2d_pkg::MEAN_W-1:0];
            o_last_in_frame <= r_last;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_status.need_out = r_has_out;
    assign o_status.div_done = r_busy && (r_step == STW'(DVW - 1));
    assign o_status.out_free = !r_ovalid || i_ready;

endmodule

// ===== design/box_mean_filter_2d_unit.sv =====
// Top level of the streaming 2-D box mean filter.
// Depends on bmf2d_pkg, bmf2d_ctrl and bmf2d_dpath.
//
// Pixels arrive in raster order over an extended raster of (height+radius)
// rows by (width+radius) columns; padding positions count as zero. Each
// image pixel's window mean (8 fraction bits, truncated, window clipped to
// the image) comes out radius rows and columns later. One pixel is taken per
// item: a beat that yields no mean passes through accept and column/line
// store update; a beat that yields a mean also runs the one bit per cycle
// divider by the clipped pixel count, then waits for a free output register.
// A finished mean waits in the output register while the next pixel is
// taken. Configuration writes take effect at once and belong only between
// frames or while idle.
module box_mean_filter_2d_unit #(
    parameter int MAX_WIDTH  = bmf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = bmf2d_pkg::MAX_RADIUS_DEF,
    parameter int PIXEL_BITS = bmf2d_pkg::PIXEL_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [bmf2d_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmf2d_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [PIXEL_BITS-1:0]            i_pixel,
    // mean output
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [bmf2d_pkg::MEAN_W-1:0]     o_mean,
    output logic                             o_last_in_frame
);

    bmf2d_pkg::t_cmd    cmd;
    bmf2d_pkg::t_status status;

    bmf2d_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    bmf2d_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pixel         (i_pixel),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_mean          (o_mean),
        .o_last_in_frame (o_last_in_frame)
    );

endmodule
